// File: rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// shared sizes, operation codes and cell control types for the bounded deque
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 3 * DATA_W + CNT_W + 1 + STAT_W;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ROTATE     = 3'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_BACK,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] word;
  } cell_ctrl_t;

endpackage

// File: rtl/core/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// one slot of the deque chain: holds a word and its valid flag, takes its
// neighbor's word on a front push or rotate
// ----------------------------------------------------------------------------
module bdq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bdq_pkg::cell_ctrl_t        ctrl,
  input  logic [bdq_pkg::DATA_W-1:0] left_data,
  input  logic                       left_valid,
  input  logic                       right_valid,
  output logic [bdq_pkg::DATA_W-1:0] data_o,
  output logic                       valid_o,
  output logic                       is_back_o
);

  logic [bdq_pkg::DATA_W-1:0] data_r;
  logic [bdq_pkg::DATA_W-1:0] data_nxt;
  logic                       valid_r;
  logic                       valid_nxt;
  logic                       is_back;

  assign is_back = valid_r & ~right_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (ctrl.op)
      bdq_pkg::CELL_PUSH_FRONT: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      bdq_pkg::CELL_PUSH_BACK: begin
        // first free slot takes the word
        if (!valid_r && left_valid) begin
          data_nxt  = ctrl.word;
          valid_nxt = 1'b1;
        end
      end
      bdq_pkg::CELL_POP_BACK: begin
        if (is_back) begin
          valid_nxt = 1'b0;
        end
      end
      bdq_pkg::CELL_ROTATE: begin
        data_nxt = left_data;
      end
      default: begin
        data_nxt  = data_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data_o    = data_r;
  assign valid_o   = valid_r;
  assign is_back_o = is_back;

endmodule

// File: rtl/core/bounded_deque_with_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_rotate
// bounded double-ended queue built as a shifting chain of word cells
// ----------------------------------------------------------------------------
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+------------------------------------
// in_      | in  | in_tvalid/tready   | tuser: kind, tdata: value
// out_     | out | out_tvalid/tready  | tdata: popped, front, back, count,
//          |     |                    |        is_empty, status
//
// for each word, the accept cycle applies the operation to the
// cell chain, and the following cycle reads the new front and back off the chain
// into the output register
// a new word is taken when no word is in flight and the output register is
// empty or being drained in the same cycle
// reset (rst_n low, synchronous) clears every cell's valid flag, the count
// and the handshake state; cell data is left as is
// output stalls hold the result register and block further input
//
module bounded_deque_with_rotate (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bdq_pkg::DATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic [bdq_pkg::KIND_W-1:0]   in_tuser,   // [2:0] kind
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [31:0] popped, [63:32] front_word, [95:64] back_word, [100:96] count,
  // [101] is_empty, [103:102] status
  output logic [bdq_pkg::OUT_TW-1:0]   out_tdata
);

  localparam int DEPTH  = bdq_pkg::DEPTH;
  localparam int DATA_W = bdq_pkg::DATA_W;
  localparam int CNT_W  = bdq_pkg::CNT_W;

  // cell chain taps
  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_back;
  logic [DATA_W-1:0] back_word;
  logic              chain_full;
  logic              chain_empty;

  bdq_pkg::cell_ctrl_t ctrl;
  logic [DATA_W-1:0]   head_word;

  // handshake and result state
  logic                       pend_r;
  logic                       out_valid_r;
  logic [DATA_W-1:0]          popped_r;
  logic [DATA_W-1:0]          popped_nxt;
  logic [bdq_pkg::STAT_W-1:0] status_r;
  logic [bdq_pkg::STAT_W-1:0] status_nxt;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;
  logic [bdq_pkg::OUT_TW-1:0] out_data_r;
  logic [bdq_pkg::OUT_TW-1:0] out_data_nxt;
  logic                       in_acc;

  // the back cell is the only one flagged, so an or of masked words selects it
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | (cell_data[i] & {DATA_W{cell_back[i]}});
    end
  end

  assign chain_full  = cell_valid[DEPTH-1];
  assign chain_empty = ~cell_valid[0];

  assign in_tready = ~pend_r & (~out_valid_r | out_tready);
  assign in_acc    = in_tvalid & in_tready;

  // decode the request into a chain command, status and new count
  always_comb begin
    ctrl.op    = bdq_pkg::CELL_HOLD;
    ctrl.word  = in_tdata;
    popped_nxt = '0;
    status_nxt = bdq_pkg::STAT_OK;
    count_nxt  = count_r;
    case (in_tuser)
      bdq_pkg::KIND_PUSH_FRONT: begin
        if (chain_full) begin
          status_nxt = bdq_pkg::STAT_FULL;
        end else begin
          ctrl.op   = bdq_pkg::CELL_PUSH_FRONT;
          count_nxt = count_r + 1'b1;
        end
      end
      bdq_pkg::KIND_PUSH_BACK: begin
        if (chain_full) begin
          status_nxt = bdq_pkg::STAT_FULL;
        end else begin
          ctrl.op   = bdq_pkg::CELL_PUSH_BACK;
          count_nxt = count_r + 1'b1;
        end
      end
      bdq_pkg::KIND_POP_BACK: begin
        if (chain_empty) begin
          status_nxt = bdq_pkg::STAT_EMPTY;
        end else begin
          ctrl.op    = bdq_pkg::CELL_POP_BACK;
          popped_nxt = back_word;
          count_nxt  = count_r - 1'b1;
        end
      end
      bdq_pkg::KIND_ROTATE: begin
        // with a single word the shift leaves the visible contents unchanged
        if (chain_empty) begin
          status_nxt = bdq_pkg::STAT_EMPTY;
        end else begin
          ctrl.op = bdq_pkg::CELL_ROTATE;
        end
      end
      default: begin
        ctrl.op = bdq_pkg::CELL_HOLD;
      end
    endcase
    if (!in_acc) begin
      ctrl.op = bdq_pkg::CELL_HOLD;
    end
  end

  // word entering the front cell: the back word on rotate, else the input
  assign head_word = (ctrl.op == bdq_pkg::CELL_ROTATE) ? back_word : in_tdata;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] l_data;
    logic              l_valid;
    logic              r_valid;
    if (g == 0) begin : g_first
      assign l_data  = head_word;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[g-1];
      assign l_valid = cell_valid[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_valid = cell_valid[g+1];
    end
    bdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_valid (r_valid),
      .data_o      (cell_data[g]),
      .valid_o     (cell_valid[g]),
      .is_back_o   (cell_back[g])
    );
  end

  // result word, built from the chain in the cycle after the operation
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[DATA_W-1:0]          = popped_r;
    out_data_nxt[2*DATA_W-1:DATA_W]   = cell_data[0] & {DATA_W{cell_valid[0]}};
    out_data_nxt[3*DATA_W-1:2*DATA_W] = back_word;
    out_data_nxt[3*DATA_W+CNT_W-1:3*DATA_W] = count_r;
    out_data_nxt[3*DATA_W+CNT_W]      = (count_r == '0);
    out_data_nxt[3*DATA_W+CNT_W+bdq_pkg::STAT_W:3*DATA_W+CNT_W+1] = status_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
    if (pend_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      pend_r <= in_acc;
      if (in_acc) begin
        count_r <= count_nxt;
      end
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: dv/tb_bounded_deque_with_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_rotate
// self-checking bench for the bounded deque with rotate
// ----------------------------------------------------------------------------
// a directed opening covers the empty, single-word and full corners and every
// request kind, then random phases push the deque up to full and drain it
// again. a local ring/head/count copy predicts each result word, and each
// result is compared field by field in order of acceptance. both sides idle
// in random bursts, the receiver once holds off long enough to back up the
// input, and the sender twice waits for all outstanding results to drain
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_rotate;
  import bdq_pkg::*;

  // request kinds not named in the package
  localparam logic [KIND_W-1:0] KIND_QUERY        = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LAST         = 3'd7;

  localparam int N_RANDOM   = 1720;
  localparam int TAIL_WORDS = 200;   // no idling in the last stretch
  localparam int HOLD_AT    = 400;   // results seen before the long hold-off
  localparam int HOLD_LEN   = 300;   // cycles of the long hold-off
  localparam int IDLE_LIMIT = 4000;  // cycles with no handshake on either side

  // one request word as queued for the driver
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
  } deque_req_t;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              is_empty;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] back_word;
    logic [DATA_W-1:0] front_word;
    logic [DATA_W-1:0] popped;
  } deque_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata = '0;   // [31:0] value
  logic [KIND_W-1:0]   in_tuser = '0;   // [2:0] kind
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [31:0] popped, [63:32] front_word, [95:64] back_word, [100:96] count,
  // [101] is_empty, [103:102] status
  logic [OUT_TW-1:0]   out_tdata;

  bounded_deque_with_rotate u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // deque shadow: ring, head slot and word count
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] shadow_ring [DEPTH];
  int                shadow_head;
  int                shadow_cnt;

  deque_req_t        stim_q[$];        // words still to be offered
  deque_result_t     result_q[$];      // predicted results, oldest first

  int n_total;
  int n_issued;
  int n_in;
  int n_out;
  int n_bad;
  int n_refused;
  int n_on_empty;
  int n_filled;
  int n_rot_moves;
  int idle_cycles;
  int drain_at_a;
  int drain_at_b;

  // apply one request to the shadow and return the result it should produce
  function automatic deque_result_t predict_deque(input logic [KIND_W-1:0] kind,
                                                  input logic [DATA_W-1:0] value);
    deque_result_t     r;
    logic [DATA_W-1:0] moved;
    r = '0;
    r.status = STAT_OK;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (shadow_cnt == DEPTH) begin
          r.status = STAT_FULL;
          n_refused++;
        end else begin
          if (kind == KIND_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_ring[shadow_head] = value;
          end else begin
            shadow_ring[(shadow_head + shadow_cnt) % DEPTH] = value;
          end
          shadow_cnt++;
          if (shadow_cnt == DEPTH) n_filled++;
        end
      end
      KIND_POP_BACK: begin
        if (shadow_cnt == 0) begin
          r.status = STAT_EMPTY;
          n_on_empty++;
        end else begin
          r.popped = shadow_ring[(shadow_head + shadow_cnt - 1) % DEPTH];
          shadow_cnt--;
        end
      end
      KIND_ROTATE: begin
        if (shadow_cnt == 0) begin
          r.status = STAT_EMPTY;
          n_on_empty++;
        end else if (shadow_cnt > 1) begin
          // single word: rotation is a no-op
          moved = shadow_ring[(shadow_head + shadow_cnt - 1) % DEPTH];
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_head] = moved;
          n_rot_moves++;
        end
      end
      default: ;  // query and unused kinds only report
    endcase
    if (shadow_cnt > 0) begin
      r.front_word = shadow_ring[shadow_head];
      r.back_word  = shadow_ring[(shadow_head + shadow_cnt - 1) % DEPTH];
    end
    r.count    = shadow_cnt[CNT_W-1:0];
    r.is_empty = (shadow_cnt == 0);
    return r;
  endfunction

  task automatic queue_req(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
    deque_req_t q;
    q.kind  = kind;
    q.value = value;
    stim_q.push_back(q);
  endtask

  // corner-heavy data: zero, all ones, or anything
  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus: directed opening, then random phases with a shifting push bias
  // --------------------------------------------------------------------------
  initial begin
    int push_pct;
    int roll;
    int i;

    // empty corners and report-only kinds
    queue_req(KIND_POP_BACK, 32'h1234_5678);
    queue_req(KIND_ROTATE, '1);
    queue_req(KIND_QUERY, '1);
    queue_req(KIND_UNUSED_FIRST, 32'hdead_beef);
    // first insert, single-word rotate, last pop
    queue_req(KIND_PUSH_FRONT, '0);
    queue_req(KIND_ROTATE, '0);
    queue_req(KIND_POP_BACK, '0);
    queue_req(KIND_PUSH_BACK, '1);
    queue_req(KIND_PUSH_FRONT, 32'ha5a5_a5a5);
    queue_req(KIND_ROTATE, 32'h5a5a_5a5a);
    // fill to full from both ends, then push into a full deque
    for (i = 0; i < DEPTH - 2; i++) begin
      queue_req((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, $urandom);
    end
    queue_req(KIND_PUSH_FRONT, 32'h0f0f_0f0f);
    queue_req(KIND_PUSH_BACK, 32'hf0f0_f0f0);
    drain_at_a = stim_q.size();

    push_pct = 50;
    for (i = 0; i < N_RANDOM; i++) begin
      // new phase every 40 words: fill hard, balanced, or drain hard
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 70;
          1:       push_pct = 45;
          default: push_pct = 20;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
        queue_req($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_value());
      else if (roll < 84)
        queue_req(KIND_POP_BACK, pick_value());
      else if (roll < 95)
        queue_req(KIND_ROTATE, pick_value());
      else if (roll < 98)
        queue_req(KIND_QUERY, pick_value());
      else
        queue_req(KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_LAST)), pick_value());
    end
    n_total    = stim_q.size();
    drain_at_b = n_total / 2;
  end

  // reset held low from the start, released once
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // driver: offers queued words, predicts on acceptance
  // --------------------------------------------------------------------------
  int send_gap;

  always @(posedge clk) begin
    deque_req_t q;
    bit         tail;
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      in_tdata    <= '0;
      in_tuser    <= '0;
      send_gap    = 0;
      n_issued    = 0;
      n_in        = 0;
      shadow_head = 0;
      shadow_cnt  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        result_q.push_back(predict_deque(in_tuser, in_tdata));
        n_in++;
      end
      tail = (stim_q.size() < TAIL_WORDS);
      if (in_tvalid && !in_tready) begin
        // word still pending, hold it
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if ((n_issued == drain_at_a || n_issued == drain_at_b) &&
                   result_q.size() != 0) begin
        // pause until every outstanding result has come back
        in_tvalid <= 1'b0;
      end else if (!tail && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 12);
        in_tvalid <= 1'b0;
      end else begin
        q = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= q.kind;
        in_tdata  <= q.value;
        n_issued++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each result word, drives ready with stalls
  // --------------------------------------------------------------------------
  int  stall_left;
  int  hold_left;
  bit  hold_done;

  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    bit            rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      n_out      = 0;
      n_bad      = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(deque_result_t)-1:0];
        n_out++;
        if (result_q.size() == 0) begin
          $display("%0t: result word with nothing expected: %h", $time, got);
          n_bad++;
        end else begin
          want = result_q.pop_front();
          if (got.popped !== want.popped) begin
            $display("%0t: popped exp %h got %h", $time, want.popped, got.popped);
            n_bad++;
          end
          if (got.front_word !== want.front_word) begin
            $display("%0t: front_word exp %h got %h", $time, want.front_word,
                     got.front_word);
            n_bad++;
          end
          if (got.back_word !== want.back_word) begin
            $display("%0t: back_word exp %h got %h", $time, want.back_word,
                     got.back_word);
            n_bad++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
            n_bad++;
          end
          if (got.is_empty !== want.is_empty) begin
            $display("%0t: is_empty exp %b got %b", $time, want.is_empty, got.is_empty);
            n_bad++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            n_bad++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && n_out >= HOLD_AT) begin
        // long hold-off: input backs up while the sender keeps offering
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (n_out < n_total - TAIL_WORDS && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  // cycles since the last handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("bounded_deque_with_rotate: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // end of run
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    while (n_in < n_total || result_q.size() != 0) @(posedge clk);
    // let anything stray arrive before the summary
    repeat (10) @(posedge clk);
    $display("covered %0d words, %0d results; deque filled %0d times, %0d pushes refused",
             n_in, n_out, n_filled, n_refused);
    $display("%0d pops/rotates on empty, %0d rotates that moved a word",
             n_on_empty, n_rot_moves);
    if (n_bad == 0 && result_q.size() == 0)
      $display("bounded_deque_with_rotate: match");
    else
      $display("bounded_deque_with_rotate: mismatch");
    $finish;
  end

endmodule

// File: bounded_deque_with_rotate.f
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_deque_with_rotate.sv
dv/tb_bounded_deque_with_rotate.sv
